@@ rtl/ccc_pkg.sv @@
// Shared types, constants and helpers for the calendar clock counter.
// No dependencies; every other rtl file imports this package.

package ccc_pkg;

	// field widths
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned TIME_W   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
	localparam int unsigned TDATA_W  = ((TIME_W + 7) / 8) * 8;
	localparam int unsigned FLAGS_W  = 2;

	// item kinds carried on tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK    = 2'd0,
		ACT_LOAD    = 2'd1,
		ACT_COMPARE = 2'd2
	} action_t;

	// calendar limits
	localparam logic [YEAR_W-1:0]   YEAR_LAST   = 14'd9999;
	localparam logic [MONTH_W-1:0]  MONTH_FIRST = 4'd1;
	localparam logic [MONTH_W:0]    MONTH_LAST  = 5'd12;
	localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
	localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
	localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
	localparam logic [DAY_W-1:0]    FEB_LEAP    = 5'd29;
	localparam logic [DAY_W-1:0]    FEB_COMMON  = 5'd28;
	localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;

	// divisibility by 25 via modular inverse: y*inv mod 2^14 <= (2^14-1)/25
	localparam logic [YEAR_W-1:0] DIV25_INV = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

	// stored time; year in the top bits so a packed compare orders by date
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} cal_time_t;

	// result of one step
	typedef struct packed {
		cal_time_t now;
		logic      is_equal;
		logic      is_earlier;
	} step_res_t;

	localparam cal_time_t TIME_RESET = '{
		year:   14'd2222,
		month:  4'd2,
		day:    5'd22,
		hour:   5'd2,
		minute: 6'd2,
		second: 6'd2
	};

	// days per month; February gives its common length, invalid months 31
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		case (m)
			4'd1:    d = 5'd31;
			4'd2:    d = FEB_COMMON;
			4'd3:    d = 5'd31;
			4'd4:    d = 5'd30;
			4'd5:    d = 5'd31;
			4'd6:    d = 5'd30;
			4'd7:    d = 5'd31;
			4'd8:    d = 5'd31;
			4'd9:    d = 5'd30;
			4'd10:   d = 5'd31;
			4'd11:   d = 5'd30;
			4'd12:   d = 5'd31;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/calendar_clock_counter.sv @@
// Top level of the Gregorian real-time clock calendar with stream ports.
// Depends on ccc_pkg and ccc_step.
//
//  port group  | dir | tdata                          | tuser
//  s_axis      | in  | given time (40 bits)           | action (2 bits)
//  m_axis      | out | time after the step (40 bits)  | is_equal, is_earlier
//
// One item per cycle while results are taken: an item sits in the input register, where
// the step logic (leap multiply, carry chain, compare) turns it into the
// next time, then holds in the result register until taken.
// Reset loads 2222-02-22 02:02:02 and empties both registers.
// A stalled result holds the input register; s_axis_tready stays high
// while the input register is empty or moves on in the same cycle.

module calendar_clock_counter import ccc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
	input  logic [TDATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [ACTION_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
	output logic [TDATA_W-1:0]  m_axis_tdata,
	// is_equal[0], is_earlier[1]
	output logic [FLAGS_W-1:0]  m_axis_tuser
);

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	cal_time_t           given_s1;
	cal_time_t           cur_q;
	logic                out_valid_q;
	step_res_t           out_q;
	step_res_t           res;
	cal_time_t           given_in;
	logic                out_free;
	logic                advance;
	logic                s_accept;

	// unpack the incoming word, year in the lowest bits
	assign given_in.year   = s_axis_tdata[13:0];
	assign given_in.month  = s_axis_tdata[17:14];
	assign given_in.day    = s_axis_tdata[22:18];
	assign given_in.hour   = s_axis_tdata[27:23];
	assign given_in.minute = s_axis_tdata[33:28];
	assign given_in.second = s_axis_tdata[39:34];

	// handshake
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign advance       = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;
	assign s_accept      = s_axis_tvalid & s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_s1 <= s_axis_tuser;
			given_s1  <= given_in;
		end
	end

	ccc_step u_step (
		.cur    (cur_q),
		.action (action_s1),
		.given  (given_s1),
		.res    (res)
	);

	// clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= TIME_RESET;
		end else if (advance) begin
			cur_q <= res.now;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// pack the result word
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.now.second, out_q.now.minute, out_q.now.hour,
	                        out_q.now.day, out_q.now.month, out_q.now.year};
	assign m_axis_tuser  = {out_q.is_earlier, out_q.is_equal};

endmodule

@@ rtl/ccc_leap.sv @@
// Gregorian leap-year detect for a 14-bit year.
// Depends on ccc_pkg (widths, divide-by-25 constants).

module ccc_leap import ccc_pkg::*; (
	input  logic [YEAR_W-1:0] year,
	output logic              leap
);

	logic [YEAR_W-1:0] prod;
	logic              div4;
	logic              div16;
	logic              div25;

	// exact divisibility test by 25, one low-half multiply and a compare
	assign prod  = YEAR_W'(year * DIV25_INV);
	assign div25 = (prod <= DIV25_LIM);
	assign div4  = (year[1:0] == 2'd0);
	assign div16 = (year[3:0] == 4'd0);

	// by 4 and not by 100, or by 400 (= by 16 and 25)
	assign leap = div4 & (~div25 | div16);

endmodule

@@ rtl/ccc_step.sv @@
// Next-state and compare logic for one item: tick carry chain, load, compare.
// Depends on ccc_pkg and ccc_leap.

module ccc_step import ccc_pkg::*; (
	input  cal_time_t               cur,
	input  logic [ACTION_W-1:0]     action,
	input  cal_time_t               given,
	output step_res_t               res
);

	logic              leap;
	logic [DAY_W-1:0]  days;
	logic              sec_wrap;
	logic              min_wrap;
	logic              hour_wrap;
	logic              day_roll;
	logic [MONTH_W:0]  month_inc;
	cal_time_t         ticked;

	ccc_leap u_leap (
		.year (cur.year),
		.leap (leap)
	);

	// length of the current month
	always_comb begin
		days = month_days(cur.month);
		if (cur.month == MONTH_FEB) begin
			days = leap ? FEB_LEAP : FEB_COMMON;
		end
	end

	assign sec_wrap  = (cur.second >= SECOND_LAST);
	assign min_wrap  = (cur.minute >= MINUTE_LAST);
	assign hour_wrap = (cur.hour >= HOUR_LAST);
	assign day_roll  = (cur.day >= days);
	assign month_inc = {1'b0, cur.month} + {{MONTH_W{1'b0}}, day_roll};

	// one-second advance with carries
	always_comb begin
		ticked = cur;
		if (!sec_wrap) begin
			ticked.second = cur.second + 1'b1;
		end else begin
			ticked.second = '0;
			if (!min_wrap) begin
				ticked.minute = cur.minute + 1'b1;
			end else begin
				ticked.minute = '0;
				if (!hour_wrap) begin
					ticked.hour = cur.hour + 1'b1;
				end else begin
					ticked.hour = '0;
					ticked.day  = day_roll ? DAY_FIRST : cur.day + 1'b1;
					// month past December, also a stale one, wraps the year
					if (month_inc > MONTH_LAST) begin
						ticked.month = MONTH_FIRST;
						ticked.year  = (cur.year >= YEAR_LAST) ? '0 : cur.year + 1'b1;
					end else begin
						ticked.month = month_inc[MONTH_W-1:0];
					end
				end
			end
		end
	end

	// select by item kind
	always_comb begin
		res.now        = cur;
		res.is_equal   = 1'b0;
		res.is_earlier = 1'b0;
		case (action)
			ACT_TICK: begin
				res.now = ticked;
			end
			ACT_LOAD: begin
				res.now = given;
			end
			ACT_COMPARE: begin
				res.is_equal   = (cur == given);
				res.is_earlier = (cur < given);
			end
			default: begin
				res.now = cur;
			end
		endcase
	end

endmodule

@@ sim/calendar_clock_counter_checker.sv @@
// Watches both stream ports of the calendar clock counter, predicts each result word
// from the accepted input words and compares them field by field. Depends on ccc_pkg.

module calendar_clock_counter_checker import ccc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	// year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
	input  logic [TDATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [ACTION_W-1:0] s_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
	input  logic [TDATA_W-1:0]  m_axis_tdata,
	// is_equal[0], is_earlier[1]
	input  logic [FLAGS_W-1:0]  m_axis_tuser,
	output int                  failures,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cal_time_t clock_now;
	step_res_t predicted_results[$];
	string     field_name[8] = '{"year", "month", "day", "hour", "minute", "second",
		"is_equal", "is_earlier"};

	function automatic cal_time_t unpack_time(input logic [TDATA_W-1:0] w);
		cal_time_t t;
		t.year   = w[13:0];
		t.month  = w[17:14];
		t.day    = w[22:18];
		t.hour   = w[27:23];
		t.minute = w[33:28];
		t.second = w[39:34];
		return t;
	endfunction

	// Gregorian month length; months outside 1..12 count 31 days
	function automatic int month_length(input logic [YEAR_W-1:0] year,
		input logic [MONTH_W-1:0] month);
		int y;
		y = int'(year);
		case (month)
			4'd2: begin
				if (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))
					return 29;
				return 28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: return 30;
			default: return 31;
		endcase
	endfunction

	// one second forward; out-of-range fields saturate into a carry
	function automatic cal_time_t tick_clock(input cal_time_t t);
		cal_time_t n;
		int        mon;
		n = t;
		if (n.second < SECOND_LAST) begin
			n.second = n.second + 1'b1;
			return n;
		end
		n.second = '0;
		if (n.minute < MINUTE_LAST) begin
			n.minute = n.minute + 1'b1;
			return n;
		end
		n.minute = '0;
		if (n.hour < HOUR_LAST) begin
			n.hour = n.hour + 1'b1;
			return n;
		end
		n.hour = '0;
		// day and month carry; month kept wide so 15 + 1 does not wrap
		mon = int'(n.month);
		if (n.day >= month_length(n.year, n.month)) begin
			n.day = DAY_FIRST;
			mon = mon + 1;
		end else begin
			n.day = n.day + 1'b1;
		end
		if (mon > 12) begin
			mon = 1;
			n.year = (n.year >= YEAR_LAST) ? '0 : n.year + 1'b1;
		end
		n.month = MONTH_W'(mon);
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track_clock
		cal_time_t given;
		cal_time_t got;
		step_res_t want;
		logic      eq;
		logic      lt;
		int        want_v[8];
		int        got_v[8];
		if (!arst_n) begin
			clock_now = '{year: 14'd2222, month: 4'd2, day: 5'd22, hour: 5'd2,
				minute: 6'd2, second: 6'd2};
			predicted_results.delete();
			failures = 0;
			pending = 0;
		end else begin
			// result side first: a word accepted now cannot come out at this edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result word with none expected: tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
					failures++;
				end else begin
					want = predicted_results.pop_front();
					got = unpack_time(m_axis_tdata);
					want_v = '{int'(want.now.year), int'(want.now.month),
						int'(want.now.day), int'(want.now.hour), int'(want.now.minute),
						int'(want.now.second), int'(want.is_equal), int'(want.is_earlier)};
					got_v = '{int'(got.year), int'(got.month), int'(got.day),
						int'(got.hour), int'(got.minute), int'(got.second),
						int'(m_axis_tuser[0]), int'(m_axis_tuser[1])};
					for (int i = 0; i < 8; i++) begin
						if (want_v[i] != got_v[i]) begin
							$display("%0t ns: %s expected %0d, got %0d",
								$time, field_name[i], want_v[i], got_v[i]);
							failures++;
						end
					end
				end
			end
			// input side: step the predicted clock
			if (s_axis_tvalid && s_axis_tready) begin
				given = unpack_time(s_axis_tdata);
				eq = 1'b0;
				lt = 1'b0;
				case (s_axis_tuser)
					ACT_TICK:    clock_now = tick_clock(clock_now);
					ACT_LOAD:    clock_now = given;
					// packed order is year down to second, so a plain compare orders by date
					ACT_COMPARE: begin
						eq = (clock_now == given);
						lt = (clock_now < given);
					end
					default: ;
				endcase
				predicted_results.push_back('{now: clock_now, is_equal: eq, is_earlier: lt});
			end
			pending = predicted_results.size();
		end
	end

endmodule

@@ sim/calendar_clock_counter_tb.sv @@
// Top of the calendar clock counter testbench: clock, reset, stimulus and verdict.
// Depends on ccc_pkg, the calendar_clock_counter RTL and calendar_clock_counter_checker.

module calendar_clock_counter_tb;
	import ccc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;
	localparam int                  TOTAL_WORDS = 975;
	localparam int unsigned         CYCLE_LIMIT = 300000;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;
	logic [ACTION_W-1:0] s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [FLAGS_W-1:0]  m_axis_tuser;

	int          failures;
	int          pending_words;
	int          words_sent;
	int unsigned cycle_cnt;
	bit          calm;

	calendar_clock_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	calendar_clock_counter_checker u_time_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.pending       (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic cal_time_t at_time(input int y, input int mo, input int d,
		input int h, input int mi, input int s);
		cal_time_t t;
		t.year   = YEAR_W'(y);
		t.month  = MONTH_W'(mo);
		t.day    = DAY_W'(d);
		t.hour   = HOUR_W'(h);
		t.minute = MINUTE_W'(mi);
		t.second = SECOND_W'(s);
		return t;
	endfunction

	// every bit of every field free
	function automatic cal_time_t rand_any_time();
		return at_time($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// move one field by one, up or down
	function automatic cal_time_t nudge(input cal_time_t t);
		logic up;
		up = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: t.year   = up ? t.year + 1'b1 : t.year - 1'b1;
			1: t.month  = up ? t.month + 1'b1 : t.month - 1'b1;
			2: t.day    = up ? t.day + 1'b1 : t.day - 1'b1;
			3: t.hour   = up ? t.hour + 1'b1 : t.hour - 1'b1;
			4: t.minute = up ? t.minute + 1'b1 : t.minute - 1'b1;
			default: t.second = up ? t.second + 1'b1 : t.second - 1'b1;
		endcase
		return t;
	endfunction

	// one word on the input port, after a random gap; returns once accepted
	task automatic send_word(input logic [ACTION_W-1:0] act, input cal_time_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= TDATA_W'({t.second, t.minute, t.hour, t.day, t.month, t.year});
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	task automatic hold_until_empty();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		wait (pending_words == 0);
	endtask

	// result side stalls
	initial begin : result_stalls
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (stall == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		cal_time_t t;
		int        r;
		bit        drained_mid;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_TICK;
		arst_n        = 1'b0;
		calm          = 1'b0;
		words_sent    = 0;
		drained_mid   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// from the reset time: tick, then equal, earlier and later compares
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_COMPARE, at_time(2222, 2, 22, 2, 2, 3));
		send_word(ACT_COMPARE, at_time(2222, 2, 22, 2, 2, 4));
		send_word(ACT_COMPARE, at_time(2222, 2, 22, 2, 2, 2));
		send_word(ACT_SPARE, rand_any_time());
		// month ends: leap by 400, end of leap Feb, century, leap by 4, 30-day month
		send_word(ACT_LOAD, at_time(2000, 2, 28, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_LOAD, at_time(2000, 2, 29, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_LOAD, at_time(1900, 2, 28, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_LOAD, at_time(2024, 2, 28, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_LOAD, at_time(2021, 4, 30, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		// year wrap to zero
		send_word(ACT_LOAD, at_time(9999, 12, 31, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		// all fields at full width, then a compare against all ones
		send_word(ACT_LOAD, at_time(16383, 15, 31, 31, 63, 63));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_COMPARE, at_time(16383, 15, 31, 31, 63, 63));
		// month zero counts 31 days; month 13 carries into the year
		send_word(ACT_LOAD, at_time(2005, 0, 30, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_TICK, rand_any_time());
		send_word(ACT_LOAD, at_time(2005, 13, 5, 23, 59, 59));
		send_word(ACT_TICK, rand_any_time());
		hold_until_empty();

		// random part: mostly load near a rollover, compare, tick through it
		while (words_sent < TOTAL_WORDS) begin
			if (!drained_mid && words_sent >= TOTAL_WORDS / 2) begin
				hold_until_empty();
				drained_mid = 1'b1;
			end
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 8) begin
				r = $urandom_range(0, 9);
				case (r)
					0, 1, 2: t.year = YEAR_W'($urandom_range(0, 9999));
					3:       t.year = YEAR_LAST;
					4:       t.year = YEAR_W'(100 * $urandom_range(0, 99));
					5:       t.year = YEAR_W'(400 * $urandom_range(0, 24));
					6, 7:    t.year = YEAR_W'(4 * $urandom_range(0, 2499));
					8:       t.year = YEAR_W'($urandom);
					default: t.year = YEAR_W'($urandom_range(1990, 2100));
				endcase
				t.month  = ($urandom_range(0, 6) == 0) ? MONTH_W'($urandom)
					: MONTH_W'($urandom_range(1, 12));
				t.day    = ($urandom_range(0, 3) == 0) ? DAY_W'($urandom_range(1, 31))
					: DAY_W'($urandom_range(28, 31));
				t.hour   = ($urandom_range(0, 4) == 0) ? HOUR_W'($urandom_range(0, 23))
					: HOUR_LAST;
				t.minute = ($urandom_range(0, 4) == 0) ? MINUTE_W'($urandom_range(0, 59))
					: MINUTE_LAST;
				t.second = SECOND_W'($urandom_range(50, 59));
				send_word(ACT_LOAD, t);
				send_word(ACT_COMPARE, t);
				send_word(ACT_COMPARE, nudge(t));
				repeat ($urandom_range(1, 12)) send_word(ACT_TICK, rand_any_time());
				if ($urandom_range(0, 1))
					send_word(ACT_COMPARE, nudge(t));
			end else begin
				// noise: any action, any field values
				repeat ($urandom_range(1, 4))
					send_word(ACTION_W'($urandom_range(0, 3)), rand_any_time());
			end
		end
		hold_until_empty();
		repeat (8) @(posedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ccc_pkg.sv
rtl/ccc_leap.sv
rtl/ccc_step.sv
rtl/calendar_clock_counter.sv
sim/calendar_clock_counter_checker.sv
sim/calendar_clock_counter_tb.sv
